/* rtl/core/mruc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mruc_pkg
// Shared types and constants for the MRU ordered tag cache.
// ----------------------------------------------------------------------------
package mruc_pkg;

	// Default number of cache entries.
	localparam int DEF_CACHE_ENTRIES = 16;

	// Width of one key coordinate.
	localparam int KEY_W = 32;

	// Width of the slot and order depth fields of a response.
	localparam int RSP_IDX_W = 4;

	// One stored tag: both key coordinates.
	typedef struct packed {
		logic [KEY_W-1:0] key_x;
		logic [KEY_W-1:0] key_z;
	} tag_word_t;

endpackage

/* rtl/core/mruc_order_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mruc_order_ram
// Order list memory: one write and one read port, registered read data.
// An entry that has never been written reads as its own index.
// ----------------------------------------------------------------------------
module mruc_order_ram #(
	parameter int ENTRIES = mruc_pkg::DEF_CACHE_ENTRIES,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [IDX_W-1:0] wdata,
	input  logic [IDX_W-1:0] raddr,
	output logic [IDX_W-1:0] rdata
);

	logic [IDX_W-1:0]   mem [ENTRIES];
	logic [ENTRIES-1:0] written_q;
	logic [IDX_W-1:0]   rdata_q;
	logic [IDX_W-1:0]   raddr_q;
	logic               rwritten_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
		raddr_q <= raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q  <= '0;
			rwritten_q <= 1'b0;
		end else begin
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			rwritten_q <= written_q[raddr];
		end
	end

	// After reset the order is the identity.
	assign rdata = rwritten_q ? rdata_q : raddr_q;

endmodule

/* rtl/core/mruc_tag_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mruc_tag_ram
// Tag memory indexed by slot, with a valid flag per slot.
// Read data and valid flag are registered.
// ----------------------------------------------------------------------------
module mruc_tag_ram #(
	parameter int ENTRIES = mruc_pkg::DEF_CACHE_ENTRIES,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                we,
	input  logic [IDX_W-1:0]    waddr,
	input  mruc_pkg::tag_word_t wdata,
	input  logic [IDX_W-1:0]    raddr,
	output mruc_pkg::tag_word_t rdata,
	output logic                rvalid
);

	mruc_pkg::tag_word_t mem [ENTRIES];
	logic [ENTRIES-1:0]  valid_q;
	mruc_pkg::tag_word_t rdata_q;
	logic                rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// A slot that has never received a key never hits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rvalid_q <= valid_q[raddr];
		end
	end

	assign rdata  = rdata_q;
	assign rvalid = rvalid_q;

endmodule

/* rtl/core/mru_ordered_tag_cache_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mru_ordered_tag_cache_core
// Fully associative tag cache kept in most-recently-used order.
// ----------------------------------------------------------------------------
// A request (key_x, key_z) transfers on req_valid with req_stall low. The
// order list is searched from the front, one position per cycle, through a
// two-stage read pipeline (order list, then tags). A hit at depth d moves that
// slot to the front; a miss writes the key into the slot at the back and moves
// it to the front. The move shifts one order entry per cycle through the
// order list's single write port.
// One response (hit, slot, order_depth) transfers on rsp_valid with rsp_stall
// low. The next request is taken in the cycle after the response is loaded;
// until then req_stall stays high and no new request is taken.
// The response sits in an output register: a stalled response holds while the
// next request is already being worked on, and that one then waits for the
// register to free up before it completes.
// Reset empties the cache and sets the order to slot 0 at the front; no
// clearing pass is needed, the block takes a request straight after reset.
// ----------------------------------------------------------------------------
module mru_ordered_tag_cache_core #(
	parameter int CACHE_ENTRIES = mruc_pkg::DEF_CACHE_ENTRIES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic signed [mruc_pkg::KEY_W-1:0] key_x,
	input  logic signed [mruc_pkg::KEY_W-1:0] key_z,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic                             hit,
	output logic [mruc_pkg::RSP_IDX_W-1:0]   slot,
	output logic [mruc_pkg::RSP_IDX_W-1:0]   order_depth
);

	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
	localparam int RW    = mruc_pkg::RSP_IDX_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_FRONT
	} state_t;

	state_t              state_q;
	mruc_pkg::tag_word_t key_q;
	logic [CNT_W-1:0]    srch_pos_q;
	logic                vld_s1;
	logic [IDX_W-1:0]    pos_s1;
	logic                vld_s2;
	logic [IDX_W-1:0]    pos_s2;
	logic [IDX_W-1:0]    slot_s2;
	logic [IDX_W-1:0]    sh_j_q;
	logic                sh_wv_s1;
	logic [IDX_W-1:0]    sh_wa_s1;
	logic                hit_q;
	logic [IDX_W-1:0]    slot_q;
	logic [IDX_W-1:0]    depth_q;
	logic                rsp_valid_q;
	logic                rsp_hit_q;
	logic [IDX_W-1:0]    rsp_slot_q;
	logic [IDX_W-1:0]    rsp_depth_q;

	logic                ord_we;
	logic [IDX_W-1:0]    ord_waddr;
	logic [IDX_W-1:0]    ord_wdata;
	logic [IDX_W-1:0]    ord_raddr;
	logic [IDX_W-1:0]    ord_rdata;
	logic                tag_we;
	mruc_pkg::tag_word_t tag_rdata;
	logic                tag_rvalid;
	logic                match;
	logic                rsp_free;
	logic [IDX_W+RW-1:0] slot_ext;
	logic [IDX_W+RW-1:0] depth_ext;

	mruc_order_ram #(
		.ENTRIES (CACHE_ENTRIES)
	) u_order_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ord_we),
		.waddr  (ord_waddr),
		.wdata  (ord_wdata),
		.raddr  (ord_raddr),
		.rdata  (ord_rdata)
	);

	mruc_tag_ram #(
		.ENTRIES (CACHE_ENTRIES)
	) u_tag_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (tag_we),
		.waddr  (slot_q),
		.wdata  (key_q),
		.raddr  (ord_rdata),
		.rdata  (tag_rdata),
		.rvalid (tag_rvalid)
	);

	always_comb begin
		// Shift reads walk downwards while writes trail one place above, so a
		// read never meets an entry already written.
		if (state_q == S_SEARCH) begin
			ord_raddr = srch_pos_q[IDX_W-1:0];
		end else begin
			ord_raddr = sh_j_q - 1'b1;
		end
		ord_we    = (state_q == S_FRONT) || ((state_q == S_SHIFT) && sh_wv_s1);
		ord_waddr = (state_q == S_FRONT) ? '0 : sh_wa_s1;
		ord_wdata = (state_q == S_FRONT) ? slot_q : ord_rdata;
	end

	assign tag_we    = (state_q == S_FRONT) && !hit_q;
	assign match     = tag_rvalid && (tag_rdata == key_q);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			key_q       <= '0;
			srch_pos_q  <= '0;
			vld_s1      <= 1'b0;
			pos_s1      <= '0;
			vld_s2      <= 1'b0;
			pos_s2      <= '0;
			slot_s2     <= '0;
			sh_j_q      <= '0;
			sh_wv_s1    <= 1'b0;
			sh_wa_s1    <= '0;
			hit_q       <= 1'b0;
			slot_q      <= '0;
			depth_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_hit_q   <= 1'b0;
			rsp_slot_q  <= '0;
			rsp_depth_q <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						key_q.key_x <= key_x;
						key_q.key_z <= key_z;
						srch_pos_q  <= '0;
						vld_s1      <= 1'b0;
						vld_s2      <= 1'b0;
						state_q     <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (srch_pos_q < CNT_W'(CACHE_ENTRIES)) begin
						vld_s1     <= 1'b1;
						pos_s1     <= srch_pos_q[IDX_W-1:0];
						srch_pos_q <= srch_pos_q + 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					vld_s2  <= vld_s1;
					pos_s2  <= pos_s1;
					slot_s2 <= ord_rdata;
					if (vld_s2) begin
						if (match) begin
							hit_q    <= 1'b1;
							slot_q   <= slot_s2;
							depth_q  <= pos_s2;
							sh_j_q   <= pos_s2;
							sh_wv_s1 <= 1'b0;
							vld_s1   <= 1'b0;
							vld_s2   <= 1'b0;
							state_q  <= S_SHIFT;
						end else if (pos_s2 == IDX_W'(CACHE_ENTRIES - 1)) begin
							// Miss: the slot at the back of the order is reused.
							hit_q    <= 1'b0;
							slot_q   <= slot_s2;
							depth_q  <= '0;
							sh_j_q   <= IDX_W'(CACHE_ENTRIES - 1);
							sh_wv_s1 <= 1'b0;
							vld_s1   <= 1'b0;
							vld_s2   <= 1'b0;
							state_q  <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					if (sh_j_q != '0) begin
						sh_wv_s1 <= 1'b1;
						sh_wa_s1 <= sh_j_q;
						sh_j_q   <= sh_j_q - 1'b1;
					end else begin
						sh_wv_s1 <= 1'b0;
						state_q  <= S_FRONT;
					end
				end
				S_FRONT: begin
					// The front and tag writes repeat harmlessly while the
					// output register is still occupied.
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						rsp_hit_q   <= hit_q;
						rsp_slot_q  <= slot_q;
						rsp_depth_q <= depth_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign slot_ext    = {{RW{1'b0}}, rsp_slot_q};
	assign depth_ext   = {{RW{1'b0}}, rsp_depth_q};
	assign rsp_valid   = rsp_valid_q;
	assign hit         = rsp_hit_q;
	assign slot        = slot_ext[RW-1:0];
	assign order_depth = depth_ext[RW-1:0];

endmodule

/* rtl/core/mruc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mruc_checker
// Port-level checks for the MRU ordered tag cache, bound to the top level.
// ----------------------------------------------------------------------------
module mruc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_stall,
	input logic                           rsp_valid,
	input logic                           rsp_stall,
	input logic                           hit,
	input logic [mruc_pkg::RSP_IDX_W-1:0] slot,
	input logic [mruc_pkg::RSP_IDX_W-1:0] order_depth
);

	// Only one request is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while another is in work");

	// A response needs the search and move; it cannot follow a transfer at once.
	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> !$rose(rsp_valid))
		else $error("response appeared one cycle after a request");

	// A miss reports depth zero.
	a_miss_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !hit) |-> (order_depth == '0))
		else $error("miss with non-zero order depth");

	// A stalled response holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=>
			(rsp_valid && $stable(hit) && $stable(slot) && $stable(order_depth)))
		else $error("stalled response changed");

endmodule

bind mru_ordered_tag_cache_core mruc_checker u_mruc_checker (.*);
